// ===== hdl/cr1_pkg.sv =====
// shared types, constants and bit functions of the crypto1 keystream engine
package cr1_pkg;

  localparam int unsigned HALF_W = 24;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_W  = 48;

  localparam logic [HALF_W-1:0] ODD_TAPS  = 24'h29CE5C;
  localparam logic [HALF_W-1:0] EVEN_TAPS = 24'h870804;

  localparam logic [31:0] FILT_A   = 32'h000F22C0;
  localparam logic [31:0] FILT_B   = 32'h0006C9C0;
  localparam logic [31:0] FILT_C   = 32'h0003C8B0;
  localparam logic [31:0] FILT_D   = 32'h0001E458;
  localparam logic [31:0] FILT_E   = 32'h0000D938;
  localparam logic [31:0] FILT_OUT = 32'hEC57E80A;

  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_FORWARD  = 2'd1,
    KIND_ROLLBACK = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] data_word;
    logic              feedback_enable;
  } item_t;

  // nonlinear filter over the odd half
  function automatic logic filt(input logic [HALF_W-1:0] x);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [4:0]  f;
    a = FILT_A >> x[3:0];
    b = FILT_B >> x[7:4];
    c = FILT_C >> x[11:8];
    d = FILT_D >> x[15:12];
    e = FILT_E >> x[19:16];
    f = {a[4], b[3], c[2], d[1], e[0]};
    return FILT_OUT[f];
  endfunction

  // interleaved odd/even packing of the register
  function automatic logic [KEY_W-1:0] pack(input logic [HALF_W-1:0] odd_h,
                                            input logic [HALF_W-1:0] even_h);
    logic [KEY_W-1:0] r;
    logic [4:0]       p;
    r = '0;
    for (int i = 0; i < HALF_W; i++) begin
      p = 5'(i) ^ 5'd3;
      r[2*i+1] = odd_h[p];
      r[2*i]   = even_h[p];
    end
    return r;
  endfunction

endpackage

// ===== hdl/cr1_in_reg.sv =====
// input register stage with valid/stall handshake
module cr1_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cr1_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output cr1_pkg::item_t item_o
);

  logic           valid_q;
  logic           valid_d;
  logic           take;
  cr1_pkg::item_t item_q;

  assign in_stall_o = valid_q & ~advance_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/cr1_round.sv =====
// combinational 32 step forward / rollback and key load of the cipher register
module cr1_round (
  input  cr1_pkg::item_t                     item_i,
  input  logic [cr1_pkg::HALF_W-1:0]         odd_i,
  input  logic [cr1_pkg::HALF_W-1:0]         even_i,
  input  logic [cr1_pkg::KEY_W-1:0]          key_i,
  output logic [cr1_pkg::HALF_W-1:0]         odd_o,
  output logic [cr1_pkg::HALF_W-1:0]         even_o,
  output logic [cr1_pkg::WORD_W-1:0]         keystream_o,
  output logic [cr1_pkg::KEY_W-1:0]          packed_o
);

  logic [cr1_pkg::HALF_W-1:0] o;
  logic [cr1_pkg::HALF_W-1:0] e;
  logic [cr1_pkg::HALF_W-1:0] t;
  logic [cr1_pkg::WORD_W-1:0] ks;
  logic [4:0]                 pos;
  logic [5:0]                 ko;
  logic [5:0]                 ke;
  logic                       ks_bit;
  logic                       fbk;

  always_comb begin
    o      = odd_i;
    e      = even_i;
    t      = '0;
    ks     = '0;
    pos    = '0;
    ko     = '0;
    ke     = '0;
    ks_bit = 1'b0;
    fbk    = 1'b0;
    case (item_i.kind)
      cr1_pkg::KIND_LOAD: begin
        // key bits bit-reversed within each byte, odd key positions to the odd half
        for (int k = 0; k < cr1_pkg::HALF_W; k++) begin
          ko = 6'(46 - 2 * k) ^ 6'd7;
          ke = 6'(47 - 2 * k) ^ 6'd7;
          o[cr1_pkg::HALF_W-1-k] = key_i[ko];
          e[cr1_pkg::HALF_W-1-k] = key_i[ke];
        end
      end
      cr1_pkg::KIND_FORWARD: begin
        for (int i = 0; i < cr1_pkg::WORD_W; i++) begin
          pos     = 5'(i) ^ 5'd24;
          ks_bit  = cr1_pkg::filt(o);
          ks[pos] = ks_bit;
          fbk = (^(cr1_pkg::ODD_TAPS & o)) ^ (^(cr1_pkg::EVEN_TAPS & e))
                ^ item_i.data_word[pos] ^ (ks_bit & item_i.feedback_enable);
          t = {e[cr1_pkg::HALF_W-2:0], fbk};
          e = o;
          o = t;
        end
      end
      cr1_pkg::KIND_ROLLBACK: begin
        for (int i = cr1_pkg::WORD_W - 1; i >= 0; i--) begin
          pos     = 5'(i) ^ 5'd24;
          t       = o;
          o       = e;
          ks_bit  = cr1_pkg::filt(o);
          ks[pos] = ks_bit;
          fbk = t[0] ^ (^(cr1_pkg::EVEN_TAPS & {1'b0, t[cr1_pkg::HALF_W-1:1]}))
                ^ (^(cr1_pkg::ODD_TAPS & o))
                ^ item_i.data_word[pos] ^ (ks_bit & item_i.feedback_enable);
          e = {fbk, t[cr1_pkg::HALF_W-1:1]};
        end
      end
      default: begin
        // unused kind holds the register
        o = odd_i;
        e = even_i;
      end
    endcase
  end

  assign odd_o       = o;
  assign even_o      = e;
  assign keystream_o = ks;
  assign packed_o    = cr1_pkg::pack(o, e);

endmodule

// ===== hdl/cr1_out_reg.sv =====
// result register stage with valid/stall handshake
module cr1_out_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       out_stall_i,
  input  logic [cr1_pkg::WORD_W-1:0] keystream_i,
  input  logic [cr1_pkg::KEY_W-1:0]  register_value_i,
  output logic                       out_valid_o,
  output logic [cr1_pkg::WORD_W-1:0] keystream_o,
  output logic [cr1_pkg::KEY_W-1:0]  register_value_o
);

  logic                       valid_q;
  logic                       valid_d;
  logic [cr1_pkg::WORD_W-1:0] keystream_q;
  logic [cr1_pkg::KEY_W-1:0]  register_value_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      keystream_q      <= keystream_i;
      register_value_q <= register_value_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign keystream_o      = keystream_q;
  assign register_value_o = register_value_q;

endmodule

// ===== hdl/crypto1_keystream_engine_unit.sv =====
// top level of the crypto1 keystream engine
//
// input channel: in_valid_i / in_stall_o carry one word (kind_i, data_word_i,
// feedback_enable_i); a word is taken when in_valid_i is high and in_stall_o low
// output channel: out_valid_o / out_stall_i carry keystream_o and register_value_o
// kind load copies the key into the register, forward clocks 32 steps with the
// data word mixed in, rollback undoes 32 steps; the unused kind holds the register
// an accepted word passes the input register, then the result register, which drives out_valid_o
// throughput: one word per cycle while the receiver does not stall; the 32 steps are one pass of logic between the
// input register and the result register, which also updates the cipher state
// cfg_we_i writes cfg_wdata_i into the key; write only while the block is idle
// reset clears the key, both register halves and both valid flags
// while the receiver stalls the result holds, one more word waits in the input
// register, and in_stall_o rises only when both stages are full
module crypto1_keystream_engine_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cr1_pkg::KEY_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 kind_i,
  input  logic [cr1_pkg::WORD_W-1:0] data_word_i,
  input  logic                       feedback_enable_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [cr1_pkg::WORD_W-1:0] keystream_o,
  output logic [cr1_pkg::KEY_W-1:0]  register_value_o
);

  logic [cr1_pkg::KEY_W-1:0]  key_q;
  logic [cr1_pkg::HALF_W-1:0] odd_q;
  logic [cr1_pkg::HALF_W-1:0] even_q;
  logic [cr1_pkg::HALF_W-1:0] odd_d;
  logic [cr1_pkg::HALF_W-1:0] even_d;
  logic [cr1_pkg::WORD_W-1:0] ks;
  logic [cr1_pkg::KEY_W-1:0]  packed_val;
  cr1_pkg::item_t             in_item;
  cr1_pkg::item_t             cur_item;
  logic                       cur_valid;
  logic                       advance;
  logic                       load;

  assign in_item.kind            = cr1_pkg::kind_e'(kind_i);
  assign in_item.data_word       = data_word_i;
  assign in_item.feedback_enable = feedback_enable_i;

  assign advance = ~out_valid_o | ~out_stall_i;
  assign load    = cur_valid & advance;

  cr1_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  cr1_round u_round (
    .item_i      (cur_item),
    .odd_i       (odd_q),
    .even_i      (even_q),
    .key_i       (key_q),
    .odd_o       (odd_d),
    .even_o      (even_d),
    .keystream_o (ks),
    .packed_o    (packed_val)
  );

  cr1_out_reg u_out_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (load),
    .out_stall_i      (out_stall_i),
    .keystream_i      (ks),
    .register_value_i (packed_val),
    .out_valid_o      (out_valid_o),
    .keystream_o      (keystream_o),
    .register_value_o (register_value_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      odd_q  <= '0;
      even_q <= '0;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      if (load) begin
        odd_q  <= odd_d;
        even_q <= even_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && cur_valid))
    else $error("input stalled with a free stage");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (register_value_o == cr1_pkg::pack(odd_q, even_q)))
    else $error("result register out of step with cipher state");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> cur_valid)
    else $error("accepted word lost from input stage");
`endif

endmodule
